// File: hdl/sbl_pkg.sv
// Package for the sequence boundary locator: sizes, opcodes and the structs
// passed between the search levels, the config block and the output stage.
// No dependencies.
package sbl_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    // worst-case number of halving steps over a range of MAX_ENTRIES entries
    localparam int LEVELS      = $clog2(MAX_ENTRIES + 1);

    localparam int SLOT_W  = 10;
    localparam int POS_W   = 40;
    localparam int SEQ_W   = 10;
    localparam int COUNT_W = 11;
    localparam int QLEN_W  = 16;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);
    localparam logic [QLEN_W-1:0]  QLEN_RST  = QLEN_W'(20);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0] loc;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [IDX_W-1:0] mid;
        logic [POS_W-1:0] lov;     // table[lo-1], last entry found not above loc
        logic [POS_W-1:0] hiv;     // table[hi], last entry found above loc
        logic             has_hi;  // hi has moved below the entry count
    } t_item;

    typedef struct packed {
        logic [SEQ_W-1:0] sequence_index;
        logic [POS_W-1:0] relative_location;
        logic             keep;
        logic             not_found;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]  n;      // entry count, saturated to the table depth
        logic [QLEN_W-1:0] qlen;
    } t_cfg;

endpackage

// File: hdl/sbl_in_if.sv
// Input channel of the sequence boundary locator: valid/ready plus one item.
// Depends on sbl_pkg.
interface sbl_in_if;
    import sbl_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [SLOT_W-1:0] entry_index;
    logic [POS_W-1:0]  position;

    modport source (output valid, operation, entry_index, position, input ready);
    modport sink   (input valid, operation, entry_index, position, output ready);
endinterface

// File: hdl/sbl_out_if.sv
// Result channel of the sequence boundary locator: valid/ready plus one item.
// Depends on sbl_pkg.
interface sbl_out_if;
    import sbl_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] sequence_index;
    logic [POS_W-1:0] relative_location;
    logic             keep;
    logic             not_found;

    modport source (output valid, sequence_index, relative_location, keep, not_found,
                    input ready);
    modport sink   (input valid, sequence_index, relative_location, keep, not_found,
                    output ready);
endinterface

// File: hdl/sbl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read
// with read enable. No dependencies.
module sbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/sbl_cfg.sv
// APB register block: entry_count at 0x0, query_length at 0x4.
// Depends on sbl_pkg.
module sbl_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sbl_pkg::APB_AW-1:0] paddr,
    input  logic [sbl_pkg::APB_DW-1:0] pwdata,
    output logic [sbl_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output sbl_pkg::t_cfg             o_cfg
);
    import sbl_pkg::*;

    typedef enum logic {
        REG_ENTRY_COUNT  = 1'b0,
        REG_QUERY_LENGTH = 1'b1
    } t_reg;

    logic [COUNT_W-1:0] r_count;
    logic [QLEN_W-1:0]  r_qlen;
    t_reg               w_sel;
    logic               w_wr;

    assign w_sel  = t_reg'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
            r_qlen  <= QLEN_RST;
        end else if (w_wr) begin
            unique case (w_sel)
                REG_ENTRY_COUNT:  r_count <= pwdata[COUNT_W-1:0];
                REG_QUERY_LENGTH: r_qlen  <= pwdata[QLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_ENTRY_COUNT:  prdata = APB_DW'(r_count);
            REG_QUERY_LENGTH: prdata = APB_DW'(r_qlen);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.qlen = r_qlen;
        if (32'(r_count) > 32'(MAX_ENTRIES)) begin
            o_cfg.n = CNT_W'(MAX_ENTRIES);
        end else begin
            o_cfg.n = CNT_W'(r_count);
        end
    end
endmodule

// File: hdl/sbl_level.sv
// One binary search level: its own copy of the boundary table, a stage
// register, and the compare/narrow step. Depends on sbl_pkg and sbl_ram.
module sbl_level (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  sbl_pkg::t_item i_item,
    output sbl_pkg::t_item o_item
);
    import sbl_pkg::*;

    t_item            r_item;
    logic [POS_W-1:0] w_rdata;
    logic             w_we;
    logic [CNT_W-1:0] w_span;

    // a load writes this copy as it enters the level, so items ahead of it
    // have already read here and items behind it will see the new entry
    assign w_we = i_adv && i_item.valid && (i_item.op == OP_LOAD)
               && (32'(i_item.slot) < 32'(MAX_ENTRIES));

    sbl_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(i_item.slot)),
        .i_wdata (i_item.loc),
        .i_re    (i_adv),
        .i_raddr (i_item.mid),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        o_item = r_item;
        if (r_item.op == OP_LOOKUP && r_item.lo < r_item.hi) begin
            if (w_rdata <= r_item.loc) begin
                o_item.lo  = CNT_W'(r_item.mid) + CNT_W'(1);
                o_item.lov = w_rdata;
            end else begin
                o_item.hi     = CNT_W'(r_item.mid);
                o_item.hiv    = w_rdata;
                o_item.has_hi = 1'b1;
            end
        end
        w_span     = o_item.hi - o_item.lo;
        o_item.mid = IDX_W'(o_item.lo + (w_span >> 1));
    end

    a_lo_le_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item.valid && r_item.op == OP_LOOKUP |-> r_item.lo <= r_item.hi)
        else $error("search range inverted");

    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item.valid && r_item.op == OP_LOOKUP && r_item.lo < r_item.hi
        |-> CNT_W'(r_item.mid) >= r_item.lo && CNT_W'(r_item.mid) < r_item.hi)
        else $error("probe index outside search range");
endmodule

// File: hdl/sbl_out.sv
// Result stage: forms offset, keep and not-found from the finished search,
// then an output register with a one-entry skid. Depends on sbl_pkg, sbl_out_if.
module sbl_out (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sbl_pkg::t_item          i_item,
    input  logic [sbl_pkg::QLEN_W-1:0] i_qlen,
    output logic                    o_adv,
    sbl_out_if.source               o_out
);
    import sbl_pkg::*;

    t_item            r_fin;
    t_result          w_res;
    logic             w_res_v;
    logic [POS_W:0]   w_end;
    logic             r_out_v;
    t_result          r_out;
    logic             r_skid_v;
    t_result          r_skid;

    assign o_adv   = !r_skid_v;
    assign w_res_v = r_fin.valid && (r_fin.op == OP_LOOKUP);
    assign w_end   = (POS_W+1)'(r_fin.loc) + (POS_W+1)'(i_qlen);

    always_comb begin
        w_res = '0;
        if (r_fin.lo == '0) begin
            w_res.not_found = 1'b1;
        end else begin
            w_res.sequence_index    = SEQ_W'(r_fin.lo - CNT_W'(1));
            w_res.relative_location = r_fin.loc - r_fin.lov;
            // no entry above the location counts as straddling
            w_res.keep = r_fin.has_hi && !((POS_W+1)'(r_fin.hiv) < w_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin.valid <= 1'b0;
        end else if (o_adv) begin
            r_fin <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !o_out.ready) begin
            if (o_adv && w_res_v) begin
                r_skid_v <= 1'b1;
                r_skid   <= w_res;
            end
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_out    <= r_skid;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= w_res_v;
            r_out   <= w_res;
        end
    end

    assign o_out.valid             = r_out_v;
    assign o_out.sequence_index    = r_out.sequence_index;
    assign o_out.relative_location = r_out.relative_location;
    assign o_out.keep              = r_out.keep;
    assign o_out.not_found         = r_out.not_found;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while output is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_out.ready))
        else $error("skid filled without an output stall");

    a_not_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.not_found
        |-> !r_out.keep && r_out.sequence_index == '0 && r_out.relative_location == '0)
        else $error("not-found result carries nonzero fields");
endmodule

// File: hdl/sequence_boundary_locator.sv
// Sequence boundary locator: maps a match location to the sequence holding it
// by a pipelined binary search. Depends on sbl_pkg, sbl_in_if, sbl_out_if,
// sbl_cfg, sbl_level and sbl_out.
//
// Usage: boundary start positions are loaded through the input channel with
// operation = 0 (entry_index selects the slot); loads give no result. An item
// with operation = 1 looks up a location and gives exactly one result: the
// index of the last boundary not above it, the offset from that boundary, a
// keep flag (clear when location + query_length passes the next boundary or
// no next boundary exists) and not_found when it lies below the first one.
// The user must set entry_count and query_length over APB only while no item
// is in flight; the block does not enforce it. One item is accepted every
// cycle while the skid register is empty. Each search level owns a copy of
// the table and reads it once per cycle while it advances; loads travel down
// the pipeline and write each copy in order, so loads and lookups stay ordered.
// After reset entry_count is 1 and query_length is 20; the table contents are
// undefined until loaded and no clearing pass runs. When the receiver stalls,
// one more result lands in a skid register, then input ready drops and the
// whole pipeline holds.
module sequence_boundary_locator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sbl_in_if.sink                     i_in,
    sbl_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sbl_pkg::APB_AW-1:0] paddr,
    input  logic [sbl_pkg::APB_DW-1:0] pwdata,
    output logic [sbl_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import sbl_pkg::*;

    t_cfg  w_cfg;
    logic  w_adv;
    t_item w_chain [LEVELS+1];

    sbl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_in.ready = w_adv;

    always_comb begin
        w_chain[0]        = '0;
        w_chain[0].valid  = i_in.valid;
        w_chain[0].op     = t_op'(i_in.operation);
        w_chain[0].slot   = i_in.entry_index;
        w_chain[0].loc    = i_in.position;
        w_chain[0].lo     = '0;
        w_chain[0].hi     = w_cfg.n;
        w_chain[0].mid    = IDX_W'(w_cfg.n >> 1);
        w_chain[0].has_hi = 1'b0;
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_level
        sbl_level u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_item  (w_chain[g]),
            .o_item  (w_chain[g+1])
        );
    end

    sbl_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_chain[LEVELS]),
        .i_qlen  (w_cfg.qlen),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );
endmodule

// File: dv/tb_sequence_boundary_locator.sv
// Testbench for sequence_boundary_locator: loads boundary tables, runs lookups
// under varied idle/stall rates and checks every result against a scoreboard.
// Depends on sbl_pkg, sbl_in_if, sbl_out_if and the RTL of the block.
`timescale 1ns / 1ps

class locator_scoreboard;
    logic [sbl_pkg::POS_W-1:0]   bounds [sbl_pkg::MAX_ENTRIES];
    logic [sbl_pkg::COUNT_W-1:0] entry_count;
    logic [sbl_pkg::QLEN_W-1:0]  query_length;
    sbl_pkg::t_result            awaited [$];
    int unsigned                 errors;
    int unsigned                 lookups;
    int unsigned                 loads;
    int unsigned                 misses;
    int unsigned                 straddles;

    function new();
        foreach (bounds[k]) bounds[k] = '0;
        entry_count  = sbl_pkg::COUNT_RST;
        query_length = sbl_pkg::QLEN_RST;
        errors    = 0;
        lookups   = 0;
        loads     = 0;
        misses    = 0;
        straddles = 0;
    endfunction

    function int unsigned active_entries();
        if (entry_count > sbl_pkg::MAX_ENTRIES)
            return sbl_pkg::MAX_ENTRIES;
        return int'(entry_count);
    endfunction

    // upper bound over the active entries, then step back one
    function sbl_pkg::t_result locate(input logic [sbl_pkg::POS_W-1:0] loc);
        int unsigned      n, lo, hi, mid;
        logic [31:0]      idx;
        logic [63:0]      reach;
        sbl_pkg::t_result r;
        n  = active_entries();
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (bounds[mid] <= loc)
                lo = mid + 1;
            else
                hi = mid;
        end
        r = '0;
        if (lo == 0) begin
            r.not_found = 1'b1;
        end else begin
            idx                 = lo - 1;
            r.sequence_index    = idx[sbl_pkg::SEQ_W-1:0];
            r.relative_location = loc - bounds[lo-1];
            reach               = 64'(loc) + 64'(query_length);
            // no next boundary counts as a straddle
            r.keep              = (lo < n) && !(64'(bounds[lo]) < reach);
        end
        return r;
    endfunction

    function void note_item(input sbl_pkg::t_op op,
                            input logic [sbl_pkg::SLOT_W-1:0] slot,
                            input logic [sbl_pkg::POS_W-1:0] pos);
        sbl_pkg::t_result r;
        if (op == sbl_pkg::OP_LOAD) begin
            bounds[slot] = pos;
            loads++;
        end else begin
            r = locate(pos);
            awaited.push_back(r);
            lookups++;
            if (r.not_found)
                misses++;
            else if (!r.keep)
                straddles++;
        end
    endfunction

    function void check_result(input sbl_pkg::t_result got);
        sbl_pkg::t_result want;
        if (awaited.size() == 0) begin
            $error("result with no lookup outstanding: sequence_index %0d",
                   got.sequence_index);
            errors++;
            return;
        end
        want = awaited.pop_front();
        if (got.sequence_index !== want.sequence_index) begin
            $error("sequence_index: expected %0d, got %0d",
                   want.sequence_index, got.sequence_index);
            errors++;
        end
        if (got.relative_location !== want.relative_location) begin
            $error("relative_location: expected %0h, got %0h",
                   want.relative_location, got.relative_location);
            errors++;
        end
        if (got.keep !== want.keep) begin
            $error("keep: expected %0b, got %0b", want.keep, got.keep);
            errors++;
        end
        if (got.not_found !== want.not_found) begin
            $error("not_found: expected %0b, got %0b", want.not_found, got.not_found);
            errors++;
        end
    endfunction
endclass

module tb_sequence_boundary_locator;
    import sbl_pkg::*;

    localparam int unsigned       CYCLE_LIMIT       = 400000;
    localparam int                SETTLE_CYCLES     = LEVELS + 2 + 8;
    localparam logic [APB_AW-1:0] ADDR_ENTRY_COUNT  = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_QUERY_LENGTH = 3'd4;
    localparam logic [POS_W-1:0]  POS_MAX           = '1;

    typedef enum {FILL_KEEP, FILL_SORTED, FILL_SCRAMBLED} t_fill;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sbl_in_if  in_ch ();
    sbl_out_if out_ch ();

    locator_scoreboard sb;
    int unsigned       src_idle_pct  = 0;
    int unsigned       snk_stall_pct = 0;
    int unsigned       cycle_count   = 0;
    int unsigned       settings_run  = 0;

    sequence_boundary_locator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result monitor and random backpressure
    always @(posedge i_clk) begin : rx_mon
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.sequence_index    = out_ch.sequence_index;
            got.relative_location = out_ch.relative_location;
            got.keep              = out_ch.keep;
            got.not_found         = out_ch.not_found;
            sb.check_result(got);
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic logic [POS_W-1:0] rand40();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[POS_W-1:0];
    endfunction

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_item(input t_op op, input logic [SLOT_W-1:0] slot,
                             input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.entry_index <= slot;
        in_ch.position    <= pos;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(op, slot, pos);
    endtask

    task automatic lookup(input logic [POS_W-1:0] pos);
        send_item(OP_LOOKUP, SLOT_W'($urandom), pos);
    endtask

    // loads give no result, so wait out the pipeline after the last result
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [COUNT_W-1:0] count, input logic [QLEN_W-1:0] qlen);
        apb_write(ADDR_ENTRY_COUNT, APB_DW'(count));
        sb.entry_count = count;
        apb_write(ADDR_QUERY_LENGTH, APB_DW'(qlen));
        sb.query_length = qlen;
        settings_run++;
    endtask

    // ascending starts; some duplicates and some gaps near the query length
    task automatic fill_sorted(input int unsigned n);
        logic [63:0] pos, span, step;
        pos  = 64'($urandom_range(4095));
        span = (64'd1 << POS_W) / (n == 0 ? 1 : n);
        for (int unsigned k = 0; k < n; k++) begin
            send_item(OP_LOAD, SLOT_W'(k), pos[POS_W-1:0]);
            case ($urandom_range(9))
                0:       step = 0;
                1, 2, 3: step = 64'($urandom_range(int'(sb.query_length) + 3, 1));
                default: step = {$urandom, $urandom} % span;
            endcase
            pos = pos + step;
            if (pos > 64'(POS_MAX))
                pos = 64'(POS_MAX);
        end
    endtask

    task automatic fill_scrambled(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_item(OP_LOAD, SLOT_W'(k), rand40());
    endtask

    // random locations, the two extremes, or ones near a start or near the keep threshold of the next one
    function automatic logic [POS_W-1:0] pick_location();
        int unsigned       n, k, sel;
        int                d;
        logic [POS_W-1:0]  base;
        n   = sb.active_entries();
        sel = $urandom_range(9);
        if (n == 0 || sel < 3)
            return rand40();
        if (sel == 9)
            return ($urandom_range(1) == 0) ? '0 : POS_MAX;
        k = $urandom_range(n - 1);
        if (sel < 6 || k + 1 >= n)
            base = sb.bounds[k];
        else
            base = sb.bounds[k+1] - sb.query_length;
        d = int'($urandom_range(4)) - 2;
        return base + POS_W'(d);
    endfunction

    task automatic run_phase(input logic [COUNT_W-1:0] count, input logic [QLEN_W-1:0] qlen,
                             input int unsigned src, input int unsigned snk,
                             input t_fill fill, input int items);
        logic [SLOT_W-1:0] slot;
        int                d;
        drain_results();
        configure(count, qlen);
        src_idle_pct  = src;
        snk_stall_pct = snk;
        if (fill == FILL_SORTED)
            fill_sorted(sb.active_entries());
        else if (fill == FILL_SCRAMBLED)
            fill_scrambled(sb.active_entries());
        repeat (items) begin
            if ($urandom_range(99) < 85) begin
                lookup(pick_location());
            end else begin
                slot = SLOT_W'($urandom);
                d    = int'($urandom_range(4)) - 2;
                if ($urandom_range(3) == 0)
                    send_item(OP_LOAD, slot, rand40());
                else
                    send_item(OP_LOAD, slot, sb.bounds[slot] + POS_W'(d));
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_LOAD;
        in_ch.entry_index <= '0;
        in_ch.position    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one entry, query length 20
        send_item(OP_LOAD, SLOT_W'(0), POS_W'(1000));
        lookup(POS_W'(999));
        lookup(POS_W'(1000));
        lookup('0);
        lookup(POS_MAX);
        send_item(OP_LOAD, SLOT_W'(1), POS_W'(1100));
        send_item(OP_LOAD, SLOT_W'(2), POS_MAX);
        send_item(OP_LOAD, '1, rand40());

        // keep threshold around the second start
        drain_results();
        configure(COUNT_W'(3), QLEN_RST);
        lookup(POS_W'(1079));
        lookup(POS_W'(1080));
        lookup(POS_W'(1081));
        lookup(POS_W'(1100));
        lookup(POS_MAX);
        lookup(POS_MAX - 1);

        drain_results();
        configure(COUNT_W'(3), '0);
        lookup(POS_W'(1099));
        lookup(POS_W'(1100));

        drain_results();
        configure(COUNT_W'(3), '1);
        lookup(POS_W'(1100));
        lookup(POS_MAX - 65535);
        lookup(POS_MAX - 65534);

        // empty table: everything misses
        drain_results();
        configure('0, QLEN_RST);
        lookup(POS_W'(1000));
        lookup(POS_MAX);

        run_phase('1, '1, 0, 0, FILL_SORTED, 30);
        run_phase(COUNT_W'(MAX_ENTRIES), QLEN_W'(1), 52, 0, FILL_KEEP, 30);
        run_phase(COUNT_W'(5), '0, 0, 52, FILL_SORTED, 30);
        run_phase(COUNT_W'(1), QLEN_W'(300), 37, 37, FILL_SORTED, 20);
        run_phase(COUNT_W'(17), QLEN_W'($urandom), 37, 37, FILL_SCRAMBLED, 25);
        run_phase('0, QLEN_RST, 52, 52, FILL_KEEP, 10);
        run_phase(COUNT_W'(100), QLEN_W'($urandom_range(64)), 0, 0, FILL_KEEP, 15);

        drain_results();
        $display("Checked %0d lookups (%0d below the first start, %0d straddling) after %0d loads,",
                 sb.lookups, sb.misses, sb.straddles, sb.loads);
        $display("over %0d register settings, sorted and scrambled tables, idle/stall up to 52%%.",
                 settings_run);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
